// ----- hw/rtl/tgcr_pkg.sv -----
// Shared types, constants and font table for the temperature glyph column renderer.
package tgcr_pkg;

    localparam int GLYPH_COLUMNS = 5;
    localparam int GLYPH_SLOTS   = 6;
    localparam int COL_W         = $clog2(GLYPH_COLUMNS + 1);
    localparam int SLOT_W        = $clog2(GLYPH_SLOTS);
    localparam int TEMP_W        = 9;
    localparam int BYTE_W        = 8;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic REG_UNIT_SELECT = 1'b0;

    typedef enum logic [3:0] {
        GLYPH_D0,
        GLYPH_D1,
        GLYPH_D2,
        GLYPH_D3,
        GLYPH_D4,
        GLYPH_D5,
        GLYPH_D6,
        GLYPH_D7,
        GLYPH_D8,
        GLYPH_D9,
        GLYPH_MINUS,
        GLYPH_DEGREE,
        GLYPH_CELSIUS,
        GLYPH_FAHRENHEIT
    } glyph_code_t;

    typedef struct packed {
        glyph_code_t [GLYPH_SLOTS-1:0] glyphs;
        logic [SLOT_W-1:0]             last_glyph;
    } glyph_set_t;

    typedef struct packed {
        logic pending;
        logic take;
    } slot_ctrl_t;

    // column 0 sits in the low byte
    function automatic logic [GLYPH_COLUMNS*BYTE_W-1:0] glyph_bits(input glyph_code_t code);
        logic [GLYPH_COLUMNS*BYTE_W-1:0] bits;
        begin
            unique case (code)
                GLYPH_D0:         bits = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
                GLYPH_D1:         bits = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
                GLYPH_D2:         bits = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
                GLYPH_D3:         bits = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
                GLYPH_D4:         bits = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
                GLYPH_D5:         bits = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
                GLYPH_D6:         bits = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
                GLYPH_D7:         bits = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
                GLYPH_D8:         bits = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
                GLYPH_D9:         bits = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
                GLYPH_MINUS:      bits = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
                GLYPH_DEGREE:     bits = {8'h06, 8'h09, 8'h09, 8'h06, 8'h00};
                GLYPH_CELSIUS:    bits = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
                GLYPH_FAHRENHEIT: bits = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
                default:          bits = '0;
            endcase
            return bits;
        end
    endfunction

endpackage

// ----- hw/rtl/tgcr_in_if.sv -----
// Input channel carrying one temperature word.
interface tgcr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [tgcr_pkg::TEMP_W-1:0] temperature;

    modport source (output valid, output temperature, input ready);
    modport sink   (input valid, input temperature, output ready);
endinterface

// ----- hw/rtl/tgcr_out_if.sv -----
// Output channel carrying one display column word.
interface tgcr_out_if;
    logic                         valid;
    logic                         ready;
    logic [tgcr_pkg::BYTE_W-1:0] column_byte;
    logic                         last_column;

    modport source (output valid, output column_byte, output last_column, input ready);
    modport sink   (input valid, input column_byte, input last_column, output ready);
endinterface

// ----- hw/rtl/temperature_glyph_column_renderer.sv -----
// Top level: configuration register port, decode slot and column sequencer.
// Path: decode slot register, then the sequencer list register, then the output word register.
// One column word per cycle while ready is high; an item gives 18 to 36 words (6 per glyph).
// The decode slot takes the next temperature while the sequencer still streams columns.
// Reset (rst_n low, asynchronous) clears valid flags, the sequencer and unit_select to Celsius.
module temperature_glyph_column_renderer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tgcr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tgcr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tgcr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    tgcr_in_if.sink                             sample,
    tgcr_out_if.source                          column
);
    import tgcr_pkg::*;

    logic       unit_select_reg;
    logic       unit_select_next;
    logic       reg_write;
    logic       reg_hit;
    slot_ctrl_t slot_ctrl;
    glyph_set_t glyph_set;

    assign pready    = 1'b1;
    assign reg_hit   = (paddr[APB_ADDR_W-1] == REG_UNIT_SELECT);
    assign reg_write = psel && penable && pwrite && pready && reg_hit;
    assign unit_select_next = reg_write ? pwdata[0] : unit_select_reg;
    assign prdata    = reg_hit ? {{(APB_DATA_W-1){1'b0}}, unit_select_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_select_reg <= 1'b0;
        end
        else
        begin
            unit_select_reg <= unit_select_next;
        end
    end

    tgcr_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .unit_select (unit_select_reg),
        .take        (slot_ctrl.take),
        .pending     (slot_ctrl.pending),
        .glyph_set   (glyph_set)
    );

    tgcr_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .glyph_set (glyph_set),
        .pending   (slot_ctrl.pending),
        .take      (slot_ctrl.take),
        .column    (column)
    );

endmodule

// ----- hw/rtl/tgcr_decode.sv -----
// Input slot register and digit split into a compacted glyph list.
module tgcr_decode (
    input  logic                 clk,
    input  logic                 rst_n,
    tgcr_in_if.sink              sample,
    input  logic                 unit_select,
    input  logic                 take,
    output logic                 pending,
    output tgcr_pkg::glyph_set_t glyph_set
);
    import tgcr_pkg::*;

    logic                    slot_valid_reg;
    logic                    slot_valid_next;
    logic [TEMP_W-1:0]       temp_reg;
    logic                    negative;
    logic [TEMP_W-1:0]       mag;
    logic [1:0]              hundreds;
    logic [TEMP_W-1:0]       hund_sub;
    logic [6:0]              rem;
    logic [14:0]             tens_prod;
    logic [3:0]              tens;
    logic [6:0]              tens_x10;
    logic [3:0]              ones;
    logic [GLYPH_SLOTS-1:0]  present;
    glyph_code_t [GLYPH_SLOTS-1:0] code;
    logic [SLOT_W:0]         pos;
    logic                    accept;

    assign sample.ready    = !slot_valid_reg || take;
    assign accept          = sample.valid && sample.ready;
    assign pending         = slot_valid_reg;
    assign slot_valid_next = accept ? 1'b1 : (take ? 1'b0 : slot_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            temp_reg <= sample.temperature;
        end
    end

    always_comb
    begin
        negative  = temp_reg[TEMP_W-1];
        mag       = negative ? (~temp_reg + 9'd1) : temp_reg;
        if (mag >= 9'd200)
        begin
            hundreds = 2'd2;
            hund_sub = 9'd200;
        end
        else if (mag >= 9'd100)
        begin
            hundreds = 2'd1;
            hund_sub = 9'd100;
        end
        else
        begin
            hundreds = 2'd0;
            hund_sub = 9'd0;
        end
        rem       = 7'(mag - hund_sub);
        // divide by ten: multiply by 205, drop eleven bits
        tens_prod = 15'(rem) * 15'd205;
        tens      = tens_prod[14:11];
        tens_x10  = 7'(tens) * 7'd10;
        ones      = 4'(rem - tens_x10);

        present = {1'b1, 1'b1, 1'b1, (hundreds != 2'd0) || (tens != 4'd0),
                   hundreds != 2'd0, negative};
        code[0] = GLYPH_MINUS;
        code[1] = glyph_code_t'({2'b00, hundreds});
        code[2] = glyph_code_t'(tens);
        code[3] = glyph_code_t'(ones);
        code[4] = GLYPH_DEGREE;
        code[5] = unit_select ? GLYPH_FAHRENHEIT : GLYPH_CELSIUS;

        // pack present glyphs to the front
        for (int i = 0; i < GLYPH_SLOTS; i++)
        begin
            glyph_set.glyphs[i] = GLYPH_D0;
        end
        pos = '0;
        for (int i = 0; i < GLYPH_SLOTS; i++)
        begin
            if (present[i])
            begin
                glyph_set.glyphs[pos[SLOT_W-1:0]] = code[i];
                pos = pos + 1'b1;
            end
        end
        glyph_set.last_glyph = SLOT_W'(pos - 1'b1);
    end

endmodule

// ----- hw/rtl/tgcr_emit.sv -----
// Column sequencer over the glyph list with the output word register.
module tgcr_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tgcr_pkg::glyph_set_t glyph_set,
    input  logic                 pending,
    output logic                 take,
    tgcr_out_if.source           column
);
    import tgcr_pkg::*;

    logic                          busy_reg;
    logic                          busy_next;
    glyph_code_t [GLYPH_SLOTS-1:0] list_reg;
    logic [SLOT_W-1:0]             last_glyph_reg;
    logic [SLOT_W-1:0]             glyph_reg;
    logic [SLOT_W-1:0]             glyph_next;
    logic [COL_W-1:0]              col_reg;
    logic [COL_W-1:0]              col_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [BYTE_W-1:0]             out_byte_reg;
    logic [BYTE_W-1:0]             out_byte_next;
    logic                          out_last_reg;
    logic                          out_last_next;
    logic                          out_free;
    logic                          step;
    logic                          is_last;
    logic [COL_W-1:0]              font_col;
    logic [GLYPH_COLUMNS*BYTE_W-1:0] bits;

    assign out_free = !out_valid_reg || column.ready;
    assign step     = busy_reg && out_free;
    assign is_last  = (glyph_reg == last_glyph_reg) && (col_reg == COL_W'(GLYPH_COLUMNS));
    assign take     = pending && (!busy_reg || (step && is_last));
    assign font_col = col_reg - 1'b1;
    assign bits     = glyph_bits(list_reg[glyph_reg]);

    always_comb
    begin
        busy_next      = busy_reg;
        glyph_next     = glyph_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg && !column.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
            out_last_next  = is_last;
            out_byte_next  = (col_reg == '0) ? '0 : bits[font_col*BYTE_W +: BYTE_W];
            if (col_reg == COL_W'(GLYPH_COLUMNS))
            begin
                col_next   = '0;
                glyph_next = glyph_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (take)
        begin
            busy_next  = 1'b1;
            glyph_next = '0;
            col_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            glyph_reg     <= '0;
            col_reg       <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            glyph_reg     <= glyph_next;
            col_reg       <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        if (take)
        begin
            list_reg       <= glyph_set.glyphs;
            last_glyph_reg <= glyph_set.last_glyph;
        end
    end

    assign column.valid       = out_valid_reg;
    assign column.column_byte = out_byte_reg;
    assign column.last_column = out_last_reg;

    a_glyph_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> glyph_reg <= last_glyph_reg)
        else $error("glyph index past end of list");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(GLYPH_COLUMNS))
        else $error("column index out of range");

    a_min_glyphs: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> last_glyph_reg >= SLOT_W'(2))
        else $error("glyph list shorter than three");

    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        step && is_last && !take |=> !busy_reg)
        else $error("sequencer still busy after last word");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        step && is_last |=> out_valid_reg && out_last_reg)
        else $error("last word not flagged");

endmodule

// ----- tb/temperature_glyph_column_renderer_checker.sv -----
// Checker: predicts the column words for each accepted temperature and compares them.
`timescale 1ns / 100ps
module temperature_glyph_column_renderer_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [tgcr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tgcr_pkg::APB_DATA_W-1:0] pwdata,
    tgcr_in_if                              sample,
    tgcr_out_if                             column,
    output int                              fail_count,
    output int                              columns_pending,
    output int                              columns_checked
);
    import tgcr_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] column_byte;
        logic              last_column;
    } column_word_t;

    column_word_t expected_columns[$];
    logic         fahrenheit;
    int           mismatch_count;
    int           checked_count;

    initial
    begin
        fail_count      = 0;
        columns_pending = 0;
        columns_checked = 0;
        mismatch_count  = 0;
        checked_count   = 0;
    end

    // column 0 in the top byte
    function automatic logic [GLYPH_COLUMNS*BYTE_W-1:0] glyph_strip(input glyph_code_t code);
        case (code)
            GLYPH_D0:         return 40'h3E_51_49_45_3E;
            GLYPH_D1:         return 40'h00_42_7F_40_00;
            GLYPH_D2:         return 40'h42_61_51_49_46;
            GLYPH_D3:         return 40'h21_41_45_4B_31;
            GLYPH_D4:         return 40'h18_14_12_7F_10;
            GLYPH_D5:         return 40'h27_45_45_45_39;
            GLYPH_D6:         return 40'h3C_4A_49_49_30;
            GLYPH_D7:         return 40'h01_71_09_05_03;
            GLYPH_D8:         return 40'h36_49_49_49_36;
            GLYPH_D9:         return 40'h06_49_49_29_1E;
            GLYPH_MINUS:      return 40'h08_08_08_08_08;
            GLYPH_DEGREE:     return 40'h00_06_09_09_06;
            GLYPH_CELSIUS:    return 40'h3E_41_41_41_22;
            GLYPH_FAHRENHEIT: return 40'h7F_09_09_09_01;
            default:          return '0;
        endcase
    endfunction

    function automatic void queue_temperature(input logic [TEMP_W-1:0] raw);
        glyph_code_t                     glyph_order[$];
        logic [TEMP_W:0]                 magnitude;
        logic [GLYPH_COLUMNS*BYTE_W-1:0] strip;
        column_word_t                    word;
        int                              hundreds;
        int                              tens;
        int                              ones;
        magnitude = raw[TEMP_W-1] ? ((TEMP_W+1)'(1 << TEMP_W) - {1'b0, raw}) : {1'b0, raw};
        hundreds  = int'(magnitude) / 100;
        tens      = (int'(magnitude) % 100) / 10;
        ones      = int'(magnitude) % 10;
        if (raw[TEMP_W-1])
            glyph_order.push_back(GLYPH_MINUS);
        if (hundreds > 0)
            glyph_order.push_back(glyph_code_t'(hundreds));
        if (hundreds > 0 || tens > 0)
            glyph_order.push_back(glyph_code_t'(tens));
        glyph_order.push_back(glyph_code_t'(ones));
        glyph_order.push_back(GLYPH_DEGREE);
        glyph_order.push_back(fahrenheit ? GLYPH_FAHRENHEIT : GLYPH_CELSIUS);
        foreach (glyph_order[g])
        begin
            strip = glyph_strip(glyph_order[g]);
            word  = '{column_byte: '0, last_column: 1'b0};
            expected_columns.push_back(word);
            for (int c = 0; c < GLYPH_COLUMNS; c++)
            begin
                word.column_byte = strip[(GLYPH_COLUMNS-1-c)*BYTE_W +: BYTE_W];
                word.last_column = (g == glyph_order.size() - 1) && (c == GLYPH_COLUMNS - 1);
                expected_columns.push_back(word);
            end
        end
    endfunction

    task automatic log_mismatch(input string what, input column_word_t expected,
                                input column_word_t actual);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
                     $realtime, what, expected.column_byte, expected.last_column,
                     actual.column_byte, actual.last_column);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        column_word_t expected;
        column_word_t actual;
        if (!rst_n)
        begin
            fahrenheit = 1'b0;
            expected_columns.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr[APB_ADDR_W-1:2] == REG_UNIT_SELECT)
                fahrenheit = pwdata[0];
            if (sample.valid && sample.ready)
                queue_temperature(sample.temperature);
            if (column.valid && column.ready)
            begin
                actual = '{column_byte: column.column_byte, last_column: column.last_column};
                if (expected_columns.size() == 0)
                    log_mismatch("column word with nothing pending", '0, actual);
                else
                begin
                    expected = expected_columns.pop_front();
                    checked_count++;
                    if (actual !== expected)
                        log_mismatch("column word mismatch", expected, actual);
                end
            end
        end
        fail_count      <= mismatch_count;
        columns_pending <= expected_columns.size();
        columns_checked <= checked_count;
    end

endmodule

// ----- tb/temperature_glyph_column_renderer_tb.sv -----
// Testbench top: clock, reset, register writes, temperature and column traffic, verdict.
`timescale 1ns / 100ps
module temperature_glyph_column_renderer_tb;
    import tgcr_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int UNUSED_REG_INDEX = int'(REG_UNIT_SELECT) + 1;
    localparam int RANDOM_CHUNKS    = 10;
    localparam int CHUNK_ITEMS      = 9;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    columns_pending;
    int                    columns_checked;
    int                    cycle_count;
    bit                    sender_quiet;
    bit                    receiver_quiet;
    int                    sent_count;
    int                    negative_count;
    int                    three_digit_count;
    bit [1:0]              units_used;

    int celsius_temps [14] = '{0, 1, 9, 10, 99, 100, 105, 110, 255, -1, -10, -105, -255, -256};
    int fahrenheit_temps [6] = '{200, -99, 7, 250, 101, -200};
    int ignored_write_temps [2] = '{42, -3};

    tgcr_in_if  sample_if ();
    tgcr_out_if column_if ();

    temperature_glyph_column_renderer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_if),
        .column  (column_if)
    );

    temperature_glyph_column_renderer_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .sample          (sample_if),
        .column          (column_if),
        .fail_count      (fail_count),
        .columns_pending (columns_pending),
        .columns_checked (columns_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // column side: stall a drawn number of cycles after each word
    initial
    begin
        int hold;
        hold = 0;
        column_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (column_if.valid && column_if.ready)
                hold = receiver_quiet ? 0 : $urandom_range(0, 11);
            if (hold > 0)
            begin
                column_if.ready <= 1'b0;
                hold--;
            end
            else
                column_if.ready <= 1'b1;
        end
    end

    task automatic write_register(input int index, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(index * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic select_unit(input bit fahrenheit);
        write_register(int'(REG_UNIT_SELECT),
                       ($urandom() & ~APB_DATA_W'(1)) | APB_DATA_W'(fahrenheit));
        units_used[fahrenheit] = 1'b1;
    endtask

    task automatic send_temperature(input int degrees);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_if.valid       <= 1'b1;
        sample_if.temperature <= TEMP_W'(degrees);
        do @(posedge clk); while (!sample_if.ready);
        sent_count++;
        if (degrees < 0)
            negative_count++;
        if (degrees >= 100 || degrees <= -100)
            three_digit_count++;
    endtask

    task automatic drain_columns();
        sample_if.valid <= 1'b0;
        do @(posedge clk); while (columns_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int degrees;
        int center;
        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        sample_if.valid       <= 1'b0;
        sample_if.temperature <= '0;
        receiver_quiet        <= 1'b0;
        sender_quiet      = 1'b0;
        sent_count        = 0;
        negative_count    = 0;
        three_digit_count = 0;
        units_used        = 2'b01;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (celsius_temps[i])
            send_temperature(celsius_temps[i]);
        drain_columns();
        select_unit(1'b1);
        foreach (fahrenheit_temps[i])
            send_temperature(fahrenheit_temps[i]);
        drain_columns();
        // index past the register list: unit must stay Fahrenheit
        write_register(UNUSED_REG_INDEX, '0);
        foreach (ignored_write_temps[i])
            send_temperature(ignored_write_temps[i]);
        drain_columns();

        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++)
        begin
            select_unit(chunk < 2 ? chunk[0] : 1'($urandom_range(0, 1)));
            sender_quiet = ($urandom_range(0, 3) == 0);
            receiver_quiet <= ($urandom_range(0, 3) == 0);
            for (int n = 0; n < CHUNK_ITEMS; n++)
            begin
                case ($urandom_range(0, 3))
                    0, 1:
                    begin
                        degrees = $urandom_range(0, 511);
                        if (degrees > 255)
                            degrees -= 512;
                    end
                    2:
                    begin
                        center  = 100 * $urandom_range(0, 4);
                        degrees = center - 200 + $urandom_range(0, 20) - 10;
                        if (degrees > 255)
                            degrees = 255;
                        if (degrees < -256)
                            degrees = -256;
                    end
                    default:
                        degrees = $urandom_range(0, 18) - 9;
                endcase
                send_temperature(degrees);
            end
            drain_columns();
        end

        $display("Run covered %0d temperatures (%0d negative, %0d with three digits),",
                 sent_count, negative_count, three_digit_count);
        $display("unit mask %b, %0d column words checked across random sender and receiver stalls.",
                 units_used, columns_checked);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/tgcr_pkg.sv
hw/rtl/tgcr_in_if.sv
hw/rtl/tgcr_out_if.sv
hw/rtl/tgcr_decode.sv
hw/rtl/tgcr_emit.sv
hw/rtl/temperature_glyph_column_renderer.sv
tb/temperature_glyph_column_renderer_checker.sv
tb/temperature_glyph_column_renderer_tb.sv
